>>> hw/rtl/nv12c_pkg.sv
// ============================================================================
// nv12c_pkg: shared types and constants for the NV12 to RGB converter
// Holds the item structs, register indexes and the rational coefficient set
// from which the fixed-point coefficients are derived at elaboration.
// ============================================================================
package nv12c_pkg;

    localparam int COEF_FRAC_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd2;

    // coefficient slot within one (matrix, range) group
    localparam logic [1:0] K_RED   = 2'd0;
    localparam logic [1:0] K_GB    = 2'd1;
    localparam logic [1:0] K_GR    = 2'd2;
    localparam logic [1:0] K_BLUE  = 2'd3;

    // table index is {matrix, range, slot}; range 0 is limited
    localparam int NUM_COEF = 16;
    localparam longint unsigned COEF_NUM [NUM_COEF] = '{
        64'd357510,    64'd51512040,    64'd106895490,   64'd451860,
        64'd1402,      64'd202008,      64'd419198,      64'd1772,
        64'd4015740,   64'd3416345160,  64'd8537463240,  64'd4731780,
        64'd15748,     64'd13397432,    64'd33480248,    64'd18556
    };
    localparam longint unsigned COEF_DEN [NUM_COEF] = '{
        64'd224000,    64'd131488000,   64'd131488000,   64'd224000,
        64'd1000,      64'd587000,      64'd587000,      64'd1000,
        64'd2240000,   64'd16020480000, 64'd16020480000, 64'd2240000,
        64'd10000,     64'd71520000,    64'd71520000,    64'd10000
    };

    // limited-range luma gain 255/219
    localparam longint unsigned KY_NUM = 64'd255;
    localparam longint unsigned KY_DEN = 64'd219;

    typedef struct packed {
        logic [7:0] luma_left;
        logic [7:0] luma_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] left_first;
        logic [7:0] left_second;
        logic [7:0] left_third;
        logic [7:0] right_first;
        logic [7:0] right_second;
        logic [7:0] right_third;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

>>> hw/rtl/nv12_to_rgb_converter.sv
// ============================================================================
// nv12_to_rgb_converter: NV12 pixel pair to 8-bit RGB/BGR
// An accepted item passes through the pipeline stages below to its result strobe.
// Throughput: one item per cycle; busy never rises, the pipeline is fully fed.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
// Reset (synchronous, active low) clears the pipeline valids and sets BT.601,
// limited range and RGB order.
// ============================================================================
//
// Pipeline:
//   stage 1  shared chroma products (nv12c_chroma) and per-lane luma scaling
//   stage 2  per-lane channel sums, rounding and clamping (two nv12c_lane)
//   stage 3  byte-order merge into the output register (nv12c_merge)
// Each multiply owns its own stage-1 register; the coefficient table is
// constant, derived at elaboration from the rational coefficient set.
module nv12_to_rgb_converter #(
    parameter int COEF_FRAC_BITS = nv12c_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nv12c_pkg::t_pix_in             i_item,
    output logic                           o_result_strobe,
    output nv12c_pkg::t_pix_out            o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nv12c_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data
);
    import nv12c_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int SW = COEF_FRAC_BITS + 12;

    // coefficient = round(num / den * 2^F), ties up
    localparam longint unsigned KY_FIX =
        ((KY_NUM << (COEF_FRAC_BITS + 1)) + KY_DEN) / (KY_DEN * 64'd2);

    logic [CW-1:0] w_coef_tab [NUM_COEF];
    logic [CW-1:0] w_ky;

    logic r_matrix;
    logic r_range;
    logic r_order;
    logic r_vld1;
    logic r_vld2;
    logic w_accept;

    logic [CW-1:0] w_kr;
    logic [CW-1:0] w_kgb;
    logic [CW-1:0] w_kgr;
    logic [CW-1:0] w_kb;

    logic signed [SW-1:0] w_term_r;
    logic signed [SW-1:0] w_term_gb;
    logic signed [SW-1:0] w_term_gr;
    logic signed [SW-1:0] w_term_b;

    t_rgb w_left;
    t_rgb w_right;

    for (genvar g = 0; g < NUM_COEF; g++) begin : g_coef
        localparam longint unsigned CoefFix =
            ((COEF_NUM[g] << (COEF_FRAC_BITS + 1)) + COEF_DEN[g]) / (COEF_DEN[g] * 64'd2);
        assign w_coef_tab[g] = CoefFix[CW-1:0];
    end

    assign w_ky = KY_FIX[CW-1:0];

    // no backpressure anywhere: always take items and register writes
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    // configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix <= 1'b0;
            r_range  <= 1'b0;
            r_order  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MATRIX: r_matrix <= i_cfg_data;
                CFG_RANGE:  r_range  <= i_cfg_data;
                CFG_ORDER:  r_order  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item valid follows the datapath stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= w_accept;
            r_vld2 <= r_vld1;
        end
    end

    // select the active coefficient group
    assign w_kr  = w_coef_tab[{r_matrix, r_range, K_RED}];
    assign w_kgb = w_coef_tab[{r_matrix, r_range, K_GB}];
    assign w_kgr = w_coef_tab[{r_matrix, r_range, K_GR}];
    assign w_kb  = w_coef_tab[{r_matrix, r_range, K_BLUE}];

    nv12c_chroma #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_chroma (
        .i_clk         (i_clk),
        .i_chroma_blue (i_item.chroma_blue),
        .i_chroma_red  (i_item.chroma_red),
        .i_kr          (w_kr),
        .i_kgb         (w_kgb),
        .i_kgr         (w_kgr),
        .i_kb          (w_kb),
        .o_term_r      (w_term_r),
        .o_term_gb     (w_term_gb),
        .o_term_gr     (w_term_gr),
        .o_term_b      (w_term_b)
    );

    // left (even) pixel lane
    nv12c_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .i_clk     (i_clk),
        .i_luma    (i_item.luma_left),
        .i_full    (r_range),
        .i_ky      (w_ky),
        .i_term_r  (w_term_r),
        .i_term_gb (w_term_gb),
        .i_term_gr (w_term_gr),
        .i_term_b  (w_term_b),
        .o_pix     (w_left)
    );

    // right (odd) pixel lane
    nv12c_lane #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .i_clk     (i_clk),
        .i_luma    (i_item.luma_right),
        .i_full    (r_range),
        .i_ky      (w_ky),
        .i_term_r  (w_term_r),
        .i_term_gb (w_term_gb),
        .i_term_gr (w_term_gr),
        .i_term_b  (w_term_b),
        .o_pix     (w_right)
    );

    nv12c_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld2),
        .i_order  (r_order),
        .i_left   (w_left),
        .i_right  (w_right),
        .o_strobe (o_result_strobe),
        .o_result (o_result)
    );

    // every result strobe traces back to an accepted item
    a_strobe_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(w_accept, 3))
        else $error("result strobe without a matching item");

    // an item in the second stage always reaches the output
    a_stage2_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 |=> o_result_strobe)
        else $error("item lost between lane and merge");

    // an accepted item always leaves stage one valid
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_vld1)
        else $error("item dropped at entry");

endmodule

>>> hw/rtl/nv12c_chroma.sv
// ============================================================================
// nv12c_chroma: shared chroma products
// Multiplies the centered Cb and Cr samples by the four selected chroma
// coefficients and registers the terms for both pixel lanes.
// ============================================================================
module nv12c_chroma #(
    parameter int COEF_FRAC_BITS = nv12c_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic [7:0]                       i_chroma_blue,
    input  logic [7:0]                       i_chroma_red,
    input  logic [COEF_FRAC_BITS+1:0]        i_kr,
    input  logic [COEF_FRAC_BITS+1:0]        i_kgb,
    input  logic [COEF_FRAC_BITS+1:0]        i_kgr,
    input  logic [COEF_FRAC_BITS+1:0]        i_kb,
    output logic signed [COEF_FRAC_BITS+11:0] o_term_r,
    output logic signed [COEF_FRAC_BITS+11:0] o_term_gb,
    output logic signed [COEF_FRAC_BITS+11:0] o_term_gr,
    output logic signed [COEF_FRAC_BITS+11:0] o_term_b
);
    import nv12c_pkg::*;

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int SW = COEF_FRAC_BITS + 12;

    logic signed [SW-1:0] w_cb;
    logic signed [SW-1:0] w_cr;
    logic signed [SW-1:0] w_kr;
    logic signed [SW-1:0] w_kgb;
    logic signed [SW-1:0] w_kgr;
    logic signed [SW-1:0] w_kb;
    logic signed [SW-1:0] r_term_r;
    logic signed [SW-1:0] r_term_gb;
    logic signed [SW-1:0] r_term_gr;
    logic signed [SW-1:0] r_term_b;

    // offset binary to two's complement: flip the top bit
    assign w_cb  = {{(SW-8){~i_chroma_blue[7]}}, ~i_chroma_blue[7], i_chroma_blue[6:0]};
    assign w_cr  = {{(SW-8){~i_chroma_red[7]}}, ~i_chroma_red[7], i_chroma_red[6:0]};
    assign w_kr  = {{(SW-CW){1'b0}}, i_kr};
    assign w_kgb = {{(SW-CW){1'b0}}, i_kgb};
    assign w_kgr = {{(SW-CW){1'b0}}, i_kgr};
    assign w_kb  = {{(SW-CW){1'b0}}, i_kb};

    always_ff @(posedge i_clk) begin
        r_term_r  <= w_kr  * w_cr;
        r_term_gb <= w_kgb * w_cb;
        r_term_gr <= w_kgr * w_cr;
        r_term_b  <= w_kb  * w_cb;
    end

    assign o_term_r  = r_term_r;
    assign o_term_gb = r_term_gb;
    assign o_term_gr = r_term_gr;
    assign o_term_b  = r_term_b;

endmodule

>>> hw/rtl/nv12c_lane.sv
// ============================================================================
// nv12c_lane: one pixel lane
// Scales the luma sample, adds the shared chroma terms, then rounds half
// away from zero and clamps each channel to 0..255.
// ============================================================================
module nv12c_lane #(
    parameter int COEF_FRAC_BITS = nv12c_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic [7:0]                        i_luma,
    input  logic                              i_full,
    input  logic [COEF_FRAC_BITS+1:0]         i_ky,
    input  logic signed [COEF_FRAC_BITS+11:0] i_term_r,
    input  logic signed [COEF_FRAC_BITS+11:0] i_term_gb,
    input  logic signed [COEF_FRAC_BITS+11:0] i_term_gr,
    input  logic signed [COEF_FRAC_BITS+11:0] i_term_b,
    output nv12c_pkg::t_rgb                   o_pix
);
    import nv12c_pkg::*;

    localparam int F  = COEF_FRAC_BITS;
    localparam int CW = F + 2;
    localparam int SW = F + 12;

    logic signed [SW-1:0] w_y_ofs;
    logic signed [SW-1:0] w_ky;
    logic signed [SW-1:0] w_luma_lim;
    logic signed [SW-1:0] w_luma_full;
    logic signed [SW-1:0] r_luma_fix;
    logic signed [SW-1:0] w_sum_r;
    logic signed [SW-1:0] w_sum_g;
    logic signed [SW-1:0] w_sum_b;
    t_rgb                 r_pix;

    // negative sums clamp to zero; otherwise add half and drop the fraction
    function automatic logic [7:0] f_round_clamp(input logic signed [SW-1:0] s);
        logic [SW-1:0] q;
        q = (SW'(s) + (SW'(1) << (F - 1))) >> F;
        if (s[SW-1]) begin
            return 8'd0;
        end else if (q > SW'(255)) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

    assign w_y_ofs     = {{(SW-8){1'b0}}, i_luma} - SW'(16);
    assign w_ky        = {{(SW-CW){1'b0}}, i_ky};
    assign w_luma_lim  = w_ky * w_y_ofs;
    assign w_luma_full = {{(SW-8-F){1'b0}}, i_luma, {F{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_luma_fix <= i_full ? w_luma_full : w_luma_lim;
    end

    assign w_sum_r = r_luma_fix + i_term_r;
    assign w_sum_g = r_luma_fix - i_term_gb - i_term_gr;
    assign w_sum_b = r_luma_fix + i_term_b;

    always_ff @(posedge i_clk) begin
        r_pix.red   <= f_round_clamp(w_sum_r);
        r_pix.green <= f_round_clamp(w_sum_g);
        r_pix.blue  <= f_round_clamp(w_sum_b);
    end

    assign o_pix = r_pix;

endmodule

>>> hw/rtl/nv12c_merge.sv
// ============================================================================
// nv12c_merge: lane merge and output register
// Packs both lane pixels into one result item in RGB or BGR byte order.
// ============================================================================
module nv12c_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_order,
    input  nv12c_pkg::t_rgb     i_left,
    input  nv12c_pkg::t_rgb     i_right,
    output logic                o_strobe,
    output nv12c_pkg::t_pix_out o_result
);
    import nv12c_pkg::*;

    logic     r_strobe;
    t_pix_out r_result;
    t_pix_out n_result;

    always_comb begin
        n_result.left_first   = i_order ? i_left.blue  : i_left.red;
        n_result.left_second  = i_left.green;
        n_result.left_third   = i_order ? i_left.red   : i_left.blue;
        n_result.right_first  = i_order ? i_right.blue : i_right.red;
        n_result.right_second = i_right.green;
        n_result.right_third  = i_order ? i_right.red  : i_right.blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
